/* hdl/dshm_pkg.sv */
package dshm_pkg;

  localparam int TableEntries = 4096;
  localparam int IdxW         = $clog2(TableEntries);
  localparam int RidBits      = 19;
  localparam int EntryW       = 48 + 4 * 32;

  localparam logic [1:0] OP_LOAD     = 2'd0;
  localparam logic [1:0] OP_SID2ID   = 2'd1;
  localparam logic [1:0] OP_ID2SID   = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam logic [2:0] ST_UNMAPPED     = 3'd0;
  localparam logic [2:0] ST_MAPPED       = 3'd1;
  localparam logic [2:0] ST_REQUIRE_TYPE = 3'd2;
  localparam logic [2:0] ST_LOADED       = 3'd3;
  localparam logic [2:0] ST_SKIPPED      = 3'd4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] unix_id_in;
    logic [47:0] sid_authority;
    logic [3:0]  sid_count;
    logic [31:0] sid_word0;
    logic [31:0] sid_word1;
    logic [31:0] sid_word2;
    logic [31:0] sid_word3;
    logic [31:0] sid_word4;
    logic        type_unspecified;
    logic        logon_cache_known;
    logic        has_own_config;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [30:0] unix_id_out;
    logic [47:0] out_authority;
    logic [2:0]  out_count;
    logic [31:0] out_word0;
    logic [31:0] out_word1;
    logic [31:0] out_word2;
    logic [31:0] out_word3;
    logic [18:0] out_rid;
    logic        type_both;
  } out_item_t;

  // classified request passed from front to back
  typedef struct packed {
    logic [1:0]        opcode;
    logic [IdxW-1:0]   idx;
    logic [RidBits-1:0] rid;
    logic              hash_ok;   // domain and rid hash usable
    logic              load_ok;   // load allowed
    logic              learn_ok;  // miss may learn
    logic [EntryW-1:0] entry;
  } req_t;

  function automatic logic [IdxW-1:0] dom_hash(logic [31:0] w1, logic [31:0] w2,
                                               logic [31:0] w3);
    logic [31:0] x;
    logic [13:0] s;
    x = w1 ^ w2 ^ w3;
    s = {2'b0, x[31:20]} + {2'b0, x[19:8]} + {6'b0, x[7:0]};
    return s[IdxW-1:0];
  endfunction

endpackage

/* hdl/dshm_if.sv */
interface dshm_in_if;
  logic               valid;
  logic               ready;
  dshm_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dshm_out_if;
  logic                valid;
  logic                ready;
  dshm_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/dshm_ram.sv */
module dshm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hdl/dshm_front.sv */
module dshm_front (
  input  logic             clk,
  input  logic             rst_n,
  dshm_in_if.sink          in_ch,
  output logic             q_valid,
  output dshm_pkg::req_t   q_data,
  input  logic             q_ready
);
  dshm_pkg::in_item_t it;
  dshm_pkg::req_t     req;
  logic [dshm_pkg::IdxW-1:0] h4, hid;
  logic               is_null;
  logic               valid_r, valid_nxt;
  dshm_pkg::req_t     data_r;

  assign it  = in_ch.data;
  assign h4  = dshm_pkg::dom_hash(it.sid_word1, it.sid_word2, it.sid_word3);
  assign hid = it.unix_id_in[dshm_pkg::RidBits +: dshm_pkg::IdxW];
  assign is_null = (it.sid_authority == '0) && (it.sid_count == 4'd1) &&
                   (it.sid_word0 == '0);

  // classify the request
  always_comb begin
    req          = '0;
    req.opcode   = it.opcode;
    req.entry    = {it.sid_authority, it.sid_word0, it.sid_word1, it.sid_word2,
                    it.sid_word3};
    req.learn_ok = it.logon_cache_known || !it.type_unspecified;
    req.load_ok  = !is_null && !it.has_own_config && (it.sid_count == 4'd4) &&
                   (h4 != '0);
    case (it.opcode)
      dshm_pkg::OP_ID2SID: begin
        req.idx = hid;
        req.rid = it.unix_id_in[dshm_pkg::RidBits-1:0];
      end
      default: begin
        req.idx = h4;
        req.rid = it.sid_word4[dshm_pkg::RidBits-1:0];
      end
    endcase
    req.hash_ok = (it.sid_count == 4'd5) && (h4 != '0) && (req.rid != '0);
  end

  // one-entry queue register toward the back part
  assign in_ch.ready = !valid_r || q_ready;
  assign valid_nxt   = in_ch.ready ? in_ch.valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (in_ch.ready && in_ch.valid) begin
      data_r <= req;
    end
  end

  assign q_valid = valid_r;
  assign q_data  = data_r;
endmodule

/* hdl/dshm_back.sv */
module dshm_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  dshm_pkg::req_t  q_data,
  output logic            q_ready,
  dshm_out_if.source      out_ch
);
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_OUT   = 2'd2;
  localparam logic [1:0] S_CLEAR = 2'd3;

  localparam int IdxW = dshm_pkg::IdxW;
  localparam int RamW = dshm_pkg::EntryW + 1;

  logic [1:0]                state_r, state_nxt;
  logic [IdxW-1:0]           clr_idx_r, clr_idx_nxt;
  dshm_pkg::req_t            req_r;
  dshm_pkg::out_item_t       res, res_r;
  logic                      hit;
  logic                      upd_we;
  logic                      we;
  logic [IdxW-1:0]           waddr;
  logic [RamW-1:0]           wdata;
  logic [RamW-1:0]           rdata;

  // table entry with its valid flag on top
  dshm_ram #(.Width(RamW), .Depth(dshm_pkg::TableEntries)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (q_data.idx),
    .rdata (rdata)
  );

  assign q_ready = (state_r == S_IDLE);
  assign hit     = rdata[RamW-1];

  // clearing pass after reset, then request updates
  assign we          = (state_r == S_CLEAR) || upd_we;
  assign waddr       = (state_r == S_CLEAR) ? clr_idx_r : req_r.idx;
  assign wdata       = (state_r == S_CLEAR) ? '0 : {1'b1, req_r.entry};
  assign clr_idx_nxt = clr_idx_r + 1'b1;

  // compute result and table write in the read state
  always_comb begin
    res = '0;
    res.status = dshm_pkg::ST_UNMAPPED;
    upd_we = 1'b0;
    unique case (req_r.opcode)
      dshm_pkg::OP_LOAD: begin
        if (req_r.load_ok) begin
          res.status = dshm_pkg::ST_LOADED;
          upd_we = 1'b1;
        end else begin
          res.status = dshm_pkg::ST_SKIPPED;
        end
      end
      dshm_pkg::OP_SID2ID: begin
        if (req_r.hash_ok) begin
          if (hit || req_r.learn_ok) begin
            res.status      = dshm_pkg::ST_MAPPED;
            res.unix_id_out = {req_r.idx, req_r.rid};
            res.type_both   = 1'b1;
            upd_we = !hit;
          end else begin
            res.status = dshm_pkg::ST_REQUIRE_TYPE;
          end
        end
      end
      dshm_pkg::OP_ID2SID: begin
        if (hit) begin
          res.status = dshm_pkg::ST_MAPPED;
          {res.out_authority, res.out_word0, res.out_word1, res.out_word2,
           res.out_word3} = rdata[dshm_pkg::EntryW-1:0];
          res.out_count = 3'd5;
          res.out_rid   = req_r.rid;
          res.type_both = 1'b1;
        end
      end
      default: ;
    endcase
    if (state_r != S_READ) begin
      upd_we = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_idx_r == '1) state_nxt = S_IDLE;
      S_IDLE:  if (q_valid) state_nxt = S_READ;
      S_READ:  state_nxt = S_OUT;
      S_OUT:   if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_idx_r <= clr_idx_nxt;
      end
    end
    if (state_r == S_IDLE && q_valid) begin
      req_r <= q_data;
    end
    if (state_r == S_READ) begin
      res_r <= res;
    end
  end

  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.data  = res_r;
endmodule

/* hdl/domain_sid_hash_id_mapper_unit.sv */
// Maps Windows-style SIDs to 31-bit unix ids through a 4096-entry table of
// domain SIDs indexed by a 12-bit domain hash, and maps ids back to SIDs.
// A front stage classifies each request and hashes the domain; a back stage
// reads the table RAM, updates it and forms the result. One request is in
// the back stage at a time, passing through the RAM read, result and output
// steps, so it takes no new request before the last one is taken. Each table
// entry carries its valid flag in the RAM. After reset the back stage clears
// all 4096 table entries and takes no request until that is done; the front
// register can hold one transfer meanwhile.
module domain_sid_hash_id_mapper_unit (
  input logic       clk,
  input logic       rst_n,
  dshm_in_if.sink   in_ch,
  dshm_out_if.source out_ch
);
  logic           q_valid;
  logic           q_ready;
  dshm_pkg::req_t q_data;

  dshm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_ready (q_ready)
  );

  dshm_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_ready (q_ready),
    .out_ch  (out_ch)
  );
endmodule

/* tb/tb_domain_sid_hash_id_mapper_unit.sv */
`timescale 1ns / 100ps

module tb_domain_sid_hash_id_mapper_unit;

  localparam int CycleLimit = 400000;
  localparam int NumRandom = 650;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dshm_in_if in_ch ();
  dshm_out_if out_ch ();

  domain_sid_hash_id_mapper_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  always #5 clk = ~clk;

  // predictor copy of the domain table
  logic        dom_valid[dshm_pkg::TableEntries];
  logic [47:0] dom_auth[dshm_pkg::TableEntries];
  logic [31:0] dom_w0[dshm_pkg::TableEntries];
  logic [31:0] dom_w1[dshm_pkg::TableEntries];
  logic [31:0] dom_w2[dshm_pkg::TableEntries];
  logic [31:0] dom_w3[dshm_pkg::TableEntries];

  dshm_pkg::in_item_t  pending_reqs[$];
  dshm_pkg::out_item_t expected_replies[$];
  int        errors = 0;
  int        replies_seen = 0;
  int        cycles = 0;
  bit        quiet_tail = 1'b0;
  bit        hold_sender = 1'b0;
  int        send_gap = 0;
  int        recv_stall = 0;
  int        n_mapped = 0;
  int        n_loaded = 0;

  // 12-bit fold of the xor of sub-authorities 1..3
  function automatic logic [11:0] fold_hash(logic [31:0] a, logic [31:0] b,
                                            logic [31:0] c);
    logic [31:0] x;
    logic [13:0] s;
    x = a ^ b ^ c;
    s = {2'b0, x[31:20]} + {2'b0, x[19:8]} + {6'b0, x[7:0]};
    return s[11:0];
  endfunction

  function automatic void keep_domain(logic [11:0] h, dshm_pkg::in_item_t r);
    dom_valid[h] = 1'b1;
    dom_auth[h] = r.sid_authority;
    dom_w0[h] = r.sid_word0;
    dom_w1[h] = r.sid_word1;
    dom_w2[h] = r.sid_word2;
    dom_w3[h] = r.sid_word3;
  endfunction

  // expected reply for one request, updating the table copy
  function automatic dshm_pkg::out_item_t map_request(dshm_pkg::in_item_t r);
    dshm_pkg::out_item_t o;
    logic [11:0] hd;
    logic [18:0] hr;
    logic        is_null;
    o = '0;
    o.status = dshm_pkg::ST_UNMAPPED;
    case (r.opcode)
      dshm_pkg::OP_LOAD: begin
        is_null = (r.sid_authority == 48'd0) && (r.sid_count == 4'd1) &&
                  (r.sid_word0 == 32'd0);
        hd = (r.sid_count == 4'd4) ? fold_hash(r.sid_word1, r.sid_word2, r.sid_word3)
                                   : 12'd0;
        if (is_null || r.has_own_config || hd == 12'd0) begin
          o.status = dshm_pkg::ST_SKIPPED;
        end else begin
          keep_domain(hd, r);
          o.status = dshm_pkg::ST_LOADED;
        end
      end
      dshm_pkg::OP_SID2ID: begin
        hd = 12'd0;
        hr = 19'd0;
        if (r.sid_count == 4'd5) begin
          hd = fold_hash(r.sid_word1, r.sid_word2, r.sid_word3);
          hr = r.sid_word4[18:0];
        end
        if (hd != 12'd0 && hr != 19'd0) begin
          if (!dom_valid[hd] && !r.logon_cache_known && r.type_unspecified) begin
            o.status = dshm_pkg::ST_REQUIRE_TYPE;
          end else begin
            if (!dom_valid[hd]) keep_domain(hd, r);
            o.status = dshm_pkg::ST_MAPPED;
            o.unix_id_out = {hd, hr};
            o.type_both = 1'b1;
          end
        end
      end
      dshm_pkg::OP_ID2SID: begin
        hd = r.unix_id_in[30:19];
        if (dom_valid[hd]) begin
          o.status = dshm_pkg::ST_MAPPED;
          o.out_authority = dom_auth[hd];
          o.out_count = 3'd5;
          o.out_word0 = dom_w0[hd];
          o.out_word1 = dom_w1[hd];
          o.out_word2 = dom_w2[hd];
          o.out_word3 = dom_w3[hd];
          o.out_rid = r.unix_id_in[18:0];
          o.type_both = 1'b1;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic dshm_pkg::in_item_t rand_req();
    dshm_pkg::in_item_t r;
    r.opcode = 2'($urandom_range(0, 3));
    r.unix_id_in = $urandom();
    r.sid_authority = {16'($urandom()), 32'($urandom())};
    r.sid_count = 4'($urandom());
    r.sid_word0 = $urandom();
    r.sid_word1 = $urandom();
    r.sid_word2 = $urandom();
    r.sid_word3 = $urandom();
    r.sid_word4 = $urandom();
    r.type_unspecified = 1'($urandom());
    r.logon_cache_known = 1'($urandom());
    r.has_own_config = 1'($urandom());
    return r;
  endfunction

  // domains reused so that loads, hits and reverse lookups meet
  dshm_pkg::in_item_t known_doms[$];

  function automatic dshm_pkg::in_item_t well_formed_req();
    dshm_pkg::in_item_t r;
    dshm_pkg::in_item_t d;
    int       pick;
    r = rand_req();
    if (known_doms.size() > 0 && $urandom_range(0, 3) != 0) begin
      d = known_doms[$urandom_range(0, known_doms.size() - 1)];
      r.sid_authority = d.sid_authority;
      r.sid_word0 = d.sid_word0;
      r.sid_word1 = d.sid_word1;
      r.sid_word2 = d.sid_word2;
      r.sid_word3 = d.sid_word3;
    end else if (known_doms.size() < 40) begin
      known_doms.push_back(r);
    end
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      r.opcode = dshm_pkg::OP_LOAD;
      r.sid_count = 4'd4;
      r.has_own_config = ($urandom_range(0, 7) == 0);
    end else if (pick < 7) begin
      r.opcode = dshm_pkg::OP_SID2ID;
      r.sid_count = 4'd5;
    end else begin
      r.opcode = dshm_pkg::OP_ID2SID;
      r.unix_id_in[30:19] = fold_hash(r.sid_word1, r.sid_word2, r.sid_word3);
    end
    return r;
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) expected_replies.push_back(map_request(in_ch.data));
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(1, 15);
        in_ch.valid <= 1'b0;
      end else if (pending_reqs.size() > 0 && !hold_sender) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= pending_reqs.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    dshm_pkg::out_item_t e;
    dshm_pkg::out_item_t a;
    cycles <= cycles + 1;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        a = out_ch.data;
        replies_seen <= replies_seen + 1;
        if (expected_replies.size() == 0) begin
          $error("reply with nothing expected: status %0d", a.status);
          errors <= errors + 1;
        end else begin
          e = expected_replies.pop_front();
          if (a.status == dshm_pkg::ST_MAPPED) n_mapped <= n_mapped + 1;
          if (a.status == dshm_pkg::ST_LOADED) n_loaded <= n_loaded + 1;
          if (a != e) begin
            errors <= errors + 1;
            if (a.status != e.status)
              $error("status exp %0d got %0d", e.status, a.status);
            if (a.unix_id_out != e.unix_id_out)
              $error("unix_id_out exp %h got %h", e.unix_id_out, a.unix_id_out);
            if (a.out_authority != e.out_authority)
              $error("out_authority exp %h got %h", e.out_authority, a.out_authority);
            if (a.out_count != e.out_count)
              $error("out_count exp %0d got %0d", e.out_count, a.out_count);
            if (a.out_word0 != e.out_word0)
              $error("out_word0 exp %h got %h", e.out_word0, a.out_word0);
            if (a.out_word1 != e.out_word1)
              $error("out_word1 exp %h got %h", e.out_word1, a.out_word1);
            if (a.out_word2 != e.out_word2)
              $error("out_word2 exp %h got %h", e.out_word2, a.out_word2);
            if (a.out_word3 != e.out_word3)
              $error("out_word3 exp %h got %h", e.out_word3, a.out_word3);
            if (a.out_rid != e.out_rid)
              $error("out_rid exp %h got %h", e.out_rid, a.out_rid);
            if (a.type_both != e.type_both)
              $error("type_both exp %0d got %0d", e.type_both, a.type_both);
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        out_ch.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        recv_stall <= $urandom_range(1, 15);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("domain_sid_hash_id_mapper_unit verification failed");
      $finish;
    end
  end

  function automatic dshm_pkg::in_item_t base_req(logic [1:0] op);
    dshm_pkg::in_item_t r;
    r = '0;
    r.opcode = op;
    r.sid_authority = 48'd5;
    r.sid_count = 4'd4;
    r.sid_word0 = 32'd21;
    r.sid_word1 = 32'h1234_5678;
    r.sid_word2 = 32'h0BAD_F00D;
    r.sid_word3 = 32'h0000_0001;
    return r;
  endfunction

  initial begin
    dshm_pkg::in_item_t r;
    logic [1:0] ops[4];
    for (int i = 0; i < dshm_pkg::TableEntries; i++) dom_valid[i] = 1'b0;
    ops = '{dshm_pkg::OP_LOAD, dshm_pkg::OP_SID2ID, dshm_pkg::OP_ID2SID,
            dshm_pkg::OP_RESERVED};

    // directed: special cases and extremes
    r = base_req(dshm_pkg::OP_ID2SID); r.unix_id_in = 32'hFFFF_FFFF;
    pending_reqs.push_back(r);
    r = base_req(dshm_pkg::OP_LOAD); r.sid_count = 4'd1; r.sid_authority = 48'd0;
    r.sid_word0 = 32'd0; pending_reqs.push_back(r);              // null SID
    r = base_req(dshm_pkg::OP_LOAD); r.has_own_config = 1'b1; pending_reqs.push_back(r);
    r = base_req(dshm_pkg::OP_LOAD); r.sid_word1 = 32'd0; r.sid_word2 = 32'd0;
    r.sid_word3 = 32'd0; pending_reqs.push_back(r);              // hash zero
    r = base_req(dshm_pkg::OP_LOAD); r.sid_count = 4'd15; pending_reqs.push_back(r);
    r = base_req(dshm_pkg::OP_LOAD); r.sid_authority = '1; r.sid_word0 = '1;
    pending_reqs.push_back(r);
    r = base_req(dshm_pkg::OP_LOAD); pending_reqs.push_back(r);  // overwrite
    r = base_req(dshm_pkg::OP_SID2ID); r.sid_count = 4'd5; r.sid_word4 = 32'hFFFF_FFFF;
    pending_reqs.push_back(r);                                   // hit
    r.sid_word4 = 32'h0008_0000; pending_reqs.push_back(r);      // rid hash zero
    r.sid_count = 4'd4; r.sid_word4 = 32'd7; pending_reqs.push_back(r);
    r = base_req(dshm_pkg::OP_SID2ID); r.sid_count = 4'd5; r.sid_word4 = 32'd3;
    r.sid_word3 = 32'hFFFF_FFFF; r.type_unspecified = 1'b1;
    pending_reqs.push_back(r);                                   // require type
    r.logon_cache_known = 1'b1; pending_reqs.push_back(r);       // learn via cache
    r.sid_word3 = 32'h7777_0000; r.logon_cache_known = 1'b0;
    r.type_unspecified = 1'b0; pending_reqs.push_back(r);        // learn, typed
    r = base_req(dshm_pkg::OP_ID2SID);
    r.unix_id_in = {1'b1, fold_hash(32'h1234_5678, 32'h0BAD_F00D, 32'h1), 19'd0};
    pending_reqs.push_back(r);                                   // rid zero maps
    r = base_req(dshm_pkg::OP_ID2SID); r.unix_id_in = 32'd0; pending_reqs.push_back(r);
    r = base_req(dshm_pkg::OP_RESERVED); r.sid_count = 4'd5; pending_reqs.push_back(r);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // random: mostly well-formed, some noise
    for (int i = 0; i < NumRandom; i++) begin
      if ($urandom_range(0, 4) == 0) pending_reqs.push_back(rand_req());
      else pending_reqs.push_back(well_formed_req());
      if (i == NumRandom / 2) begin
        // hold off until the block has drained
        wait (pending_reqs.size() == 0 && !in_ch.valid);
        hold_sender = 1'b1;
        wait (expected_replies.size() == 0);
        @(posedge clk);
        hold_sender = 1'b0;
      end
      if (i == NumRandom - 120) quiet_tail = 1'b1;
    end

    wait (pending_reqs.size() == 0 && !in_ch.valid);
    wait (expected_replies.size() == 0);
    repeat (20) @(posedge clk);

    $display("Covered %0d replies: %0d loads stored, %0d mapped, ops %0d..%0d.",
             replies_seen, n_loaded, n_mapped, ops[0], ops[3]);
    if (errors == 0 && expected_replies.size() == 0) begin
      $display("domain_sid_hash_id_mapper_unit verification clean");
    end else begin
      $display("domain_sid_hash_id_mapper_unit verification failed");
    end
    $finish;
  end

endmodule
